// ----- sv/vbr_pkg.sv -----
// ---------------------------------------------------------------------------
// vbr_pkg
// shared sizes, lane types and helpers for the vector bounce reflector
// ---------------------------------------------------------------------------
`default_nettype none

package vbr_pkg;

    localparam int CW  = 16;          // component width
    localparam int PW  = 2 * CW;      // product width
    localparam int QW  = CW + 1;      // quotient bits
    localparam int TW  = CW + PW;     // wide product width
    localparam int MW  = TW + 1;      // numerator magnitude width
    localparam int SW  = MW + 1;      // signed numerator width

    localparam logic [QW:0] POS_LIM = (QW+1)'((1 << (CW - 1)) - 1);
    localparam logic [QW:0] NEG_LIM = (QW+1)'(1 << (CW - 1));

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QW-1:0] quo;
        logic [QW-1:0] low;
        logic          neg;
    } div_lane_t;

    function automatic div_lane_t div_step(input div_lane_t d, input logic [PW-1:0] nn);
        div_lane_t     r;
        logic [PW:0]   trial;
        logic          take;
        trial = {d.rem, d.low[QW-1]};
        take  = (trial >= {1'b0, nn});
        r.rem = take ? PW'(trial - {1'b0, nn}) : trial[PW-1:0];
        r.quo = {d.quo[QW-2:0], take};
        r.low = {d.low[QW-2:0], 1'b0};
        r.neg = d.neg;
        return r;
    endfunction

    function automatic logic [CW-1:0] div_finish(input div_lane_t d, input logic [PW-1:0] nn);
        logic [PW:0]   twice;
        logic [QW:0]   q;
        logic [QW:0]   lim;
        logic [CW-1:0] m;
        twice = {d.rem, 1'b0};
        q     = {1'b0, d.quo} + ((twice >= {1'b0, nn}) ? (QW+1)'(1) : (QW+1)'(0));
        lim   = d.neg ? NEG_LIM : POS_LIM;
        m     = (q > lim) ? lim[CW-1:0] : q[CW-1:0];
        return d.neg ? CW'(-m) : m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/vector_bounce_reflect.sv -----
// ---------------------------------------------------------------------------
// vector_bounce_reflect
// reflects a motion vector about a surface normal, signed fixed point
// ---------------------------------------------------------------------------
// pipeline: 4 arithmetic stages, 17 one-bit divider stages and one
// rounding/output stage lie between input transfer and result valid
// throughput: one item per cycle; the whole pipeline holds while the output stalls
// reset: all valid bits clear; payload registers are not reset
`default_nettype none

module vector_bounce_reflect
    import vbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [CW-1:0] normal_x,
    input  wire logic signed [CW-1:0] normal_y,
    input  wire logic signed [CW-1:0] motion_x,
    input  wire logic signed [CW-1:0] motion_y,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      bounced,
    output logic signed [CW-1:0]      out_x,
    output logic signed [CW-1:0]      out_y
);

    logic adv;

    // stage 1: magnitudes and small products
    logic          v1_reg;
    logic          zero1_reg;
    logic [3:0]    sgn1_reg;
    logic [CW-1:0] nxm1_reg, nym1_reg, vxm1_reg, vym1_reg;
    logic [PW-1:0] p1_reg, p2_reg, sqx_reg, sqy_reg;

    // stage 2: dot product and squared length
    logic          v2_reg, b2_reg;
    logic [3:0]    sgn2_reg;
    logic [CW-1:0] nxm2_reg, nym2_reg, vxm2_reg, vym2_reg;
    logic [PW-1:0] dot2_reg, nn2_reg;

    // stage 3: wide products
    logic          v3_reg, b3_reg;
    logic [3:0]    sgn3_reg;
    logic [PW-1:0] nn3_reg;
    logic [TW-1:0] t1x_reg, t2x_reg, t1y_reg, t2y_reg;

    // divider pipeline
    logic          dv_reg [0:QW];
    logic          db_reg [0:QW];
    logic [PW-1:0] dnn_reg [0:QW];
    div_lane_t     dx_reg [0:QW];
    div_lane_t     dy_reg [0:QW];

    logic          ov_reg, ob_reg;
    logic [CW-1:0] ox_reg, oy_reg;

    logic [CW-1:0] nxm_next, nym_next, vxm_next, vym_next;
    logic signed [PW+1:0] dot_next;
    logic signed [SW-1:0] sx_next, sy_next;
    div_lane_t     lx_next, ly_next;

    assign adv      = !(ov_reg && out_stall);
    assign in_stall = !adv;

    function automatic logic [CW-1:0] mag(input logic [CW-1:0] a);
        return a[CW-1] ? CW'(-a) : a;
    endfunction

    function automatic div_lane_t load(input logic signed [SW-1:0] s);
        div_lane_t     r;
        logic [MW-1:0] m;
        m     = s[SW-1] ? MW'(-s) : s[MW-1:0];
        r.rem = m[MW-1:QW];
        r.low = m[QW-1:0];
        r.quo = '0;
        r.neg = s[SW-1];
        return r;
    endfunction

    always_comb
    begin
        nxm_next = mag(normal_x);
        nym_next = mag(normal_y);
        vxm_next = mag(motion_x);
        vym_next = mag(motion_y);
        dot_next = (sgn1_reg[0] != sgn1_reg[2] ? -$signed({2'b00, p1_reg})
                                               :  $signed({2'b00, p1_reg}))
                 + (sgn1_reg[1] != sgn1_reg[3] ? -$signed({2'b00, p2_reg})
                                               :  $signed({2'b00, p2_reg}));
        sx_next  = (sgn3_reg[2] ? -$signed({2'b00, t1x_reg}) : $signed({2'b00, t1x_reg}))
                 + (sgn3_reg[0] ?  $signed({1'b0, t2x_reg, 1'b0})
                                : -$signed({1'b0, t2x_reg, 1'b0}));
        sy_next  = (sgn3_reg[3] ? -$signed({2'b00, t1y_reg}) : $signed({2'b00, t1y_reg}))
                 + (sgn3_reg[1] ?  $signed({1'b0, t2y_reg, 1'b0})
                                : -$signed({1'b0, t2y_reg, 1'b0}));
        lx_next  = load(sx_next);
        ly_next  = load(sy_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int k = 1; k <= QW; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            ov_reg    <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero1_reg <= (normal_x == '0 && normal_y == '0) ||
                         (motion_x == '0 && motion_y == '0);
            sgn1_reg  <= {motion_y[CW-1], motion_x[CW-1], normal_y[CW-1], normal_x[CW-1]};
            nxm1_reg  <= nxm_next;
            nym1_reg  <= nym_next;
            vxm1_reg  <= vxm_next;
            vym1_reg  <= vym_next;
            p1_reg    <= nxm_next * vxm_next;
            p2_reg    <= nym_next * vym_next;
            sqx_reg   <= nxm_next * nxm_next;
            sqy_reg   <= nym_next * nym_next;

            b2_reg    <= !zero1_reg && !dot_next[PW+1];
            sgn2_reg  <= sgn1_reg;
            nxm2_reg  <= nxm1_reg;
            nym2_reg  <= nym1_reg;
            vxm2_reg  <= vxm1_reg;
            vym2_reg  <= vym1_reg;
            dot2_reg  <= dot_next[PW-1:0];
            nn2_reg   <= sqx_reg + sqy_reg;

            b3_reg    <= b2_reg;
            sgn3_reg  <= sgn2_reg;
            nn3_reg   <= nn2_reg;
            t1x_reg   <= vxm2_reg * nn2_reg;
            t2x_reg   <= dot2_reg * nxm2_reg;
            t1y_reg   <= vym2_reg * nn2_reg;
            t2y_reg   <= dot2_reg * nym2_reg;

            db_reg[0]  <= b3_reg;
            dnn_reg[0] <= nn3_reg;
            dx_reg[0]  <= lx_next;
            dy_reg[0]  <= ly_next;
            for (int k = 1; k <= QW; k++)
            begin
                db_reg[k]  <= db_reg[k-1];
                dnn_reg[k] <= dnn_reg[k-1];
                dx_reg[k]  <= div_step(dx_reg[k-1], dnn_reg[k-1]);
                dy_reg[k]  <= div_step(dy_reg[k-1], dnn_reg[k-1]);
            end

            ob_reg <= db_reg[QW];
            ox_reg <= db_reg[QW] ? div_finish(dx_reg[QW], dnn_reg[QW]) : '0;
            oy_reg <= db_reg[QW] ? div_finish(dy_reg[QW], dnn_reg[QW]) : '0;
        end
    end

    assign out_valid = ov_reg;
    assign bounced   = ob_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

endmodule

`default_nettype wire

// ----- dv/vector_bounce_reflect_tb.sv -----
// ---------------------------------------------------------------------------
// vector_bounce_reflect_tb
// drives random and corner vector pairs into the reflector, predicts each
// reflected vector with exact wide integers and checks results in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic                     bounced;
    logic signed [vbr_pkg::CW-1:0] rx;
    logic signed [vbr_pkg::CW-1:0] ry;
} bounce_result_t;

class bounce_scoreboard;
    bounce_result_t pending[$];
    int errors;

    function automatic logic signed [15:0] reflect_axis(longint vc, longint nc, longint dot,
                                                          longint nn);
        logic signed [127:0] num;
        logic signed [127:0] mag;
        logic signed [127:0] q;
        logic signed [127:0] r;
        num = 128'(vc) * 128'(nn) - 128'(2) * 128'(dot) * 128'(nc);
        mag = num < 0 ? -num : num;
        q = mag / 128'(nn);
        r = mag % 128'(nn);
        if (2 * r >= 128'(nn))
            q = q + 1;
        if (num < 0)
        begin
            if (q > 32768)
                q = 32768;
            return 16'(-q);
        end
        if (q > 32767)
            q = 32767;
        return 16'(q);
    endfunction

    function void note_input(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] vx, logic signed [15:0] vy);
        bounce_result_t e;
        longint dot;
        longint nn;
        dot = longint'(nx) * vx + longint'(ny) * vy;
        nn = longint'(nx) * nx + longint'(ny) * ny;
        e.bounced = 0;
        e.rx = 0;
        e.ry = 0;
        if (!((nx == 0 && ny == 0) || (vx == 0 && vy == 0) || dot < 0))
        begin
            e.bounced = 1;
            e.rx = reflect_axis(vx, nx, dot, nn);
            e.ry = reflect_axis(vy, ny, dot, nn);
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic b, logic signed [15:0] x, logic signed [15:0] y);
        bounce_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result bounced=%0d x=%0d y=%0d", b, x, y);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (b !== e.bounced)
        begin
            $error("bounced expected %0d actual %0d", e.bounced, b);
            errors++;
        end
        if (x !== e.rx)
        begin
            $error("out_x expected %0d actual %0d", e.rx, x);
            errors++;
        end
        if (y !== e.ry)
        begin
            $error("out_y expected %0d actual %0d", e.ry, y);
            errors++;
        end
    endfunction
endclass

module vector_bounce_reflect_tb;
    import vbr_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [CW-1:0] normal_x = 0;
    logic signed [CW-1:0] normal_y = 0;
    logic signed [CW-1:0] motion_x = 0;
    logic signed [CW-1:0] motion_y = 0;
    logic out_valid;
    logic out_stall = 0;
    logic bounced;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;

    bounce_scoreboard sb = new();
    int cycle_count = 0;
    bit steady = 0;
    localparam int CYCLE_LIMIT = 200000;

    vector_bounce_reflect dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("vector_bounce_reflect regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(bounced, out_x, out_y);
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 17);
    end

    task automatic send_pair(logic [15:0] nx, logic [15:0] ny, logic [15:0] vx,
                             logic [15:0] vy);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        normal_x <= nx;
        normal_y <= ny;
        motion_x <= vx;
        motion_y <= vy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(nx, ny, vx, vy);
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(8)) - 16'd4;
            3: return 16'(16'sd4096 * ($urandom_range(2) - 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_pair(0, 0, 16'h1000, 0);
        send_pair(16'h1000, 0, 0, 0);
        send_pair(16'h1000, 0, 16'hf000, 0);
        send_pair(16'h1000, 0, 16'h1000, 0);
        send_pair(0, 16'h1000, 16'h1000, 16'h1000);
        send_pair(16'h1000, 0, 0, 16'h1000);
        send_pair(16'h1000, 16'h1000, 16'h1000, 16'hf000);
        send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_pair(16'h8000, 16'h7fff, 16'h8000, 16'h0001);
        send_pair(16'h0001, 16'h0001, 16'h7fff, 16'h0000);
        send_pair(16'h0001, 16'hffff, 16'h7fff, 16'h8000);
        send_pair(16'h0003, 16'h0001, 16'h0001, 16'h0001);
        send_pair(16'h0002, 16'h0001, 16'h0003, 16'h0001);
        send_pair(16'hffff, 16'h0000, 16'h8000, 16'h7fff);
        send_pair(16'h0001, 16'h0002, 16'h7fff, 16'h7fff);
        send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        drain();
        for (int i = 0; i < 1750; i++)
        begin
            steady = (i >= 600 && i < 850);
            if (i == 1200)
                drain();
            if ($urandom_range(3) == 0)
                send_pair(pick_comp(), pick_comp(), pick_comp(), pick_comp());
            else
            begin
                a = 16'($urandom);
                b = 16'($urandom);
                send_pair(a, b, 16'($urandom), 16'($urandom));
            end
        end
        steady = 0;
        drain();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("vector_bounce_reflect regression: pass");
        else
            $display("vector_bounce_reflect regression: fail");
        $finish;
    end
endmodule
